### design/luhn_card_brand_check_assert.svh
// Assertion macros for the card check block
`ifndef LUHN_CARD_BRAND_CHECK_ASSERT_SVH
`define LUHN_CARD_BRAND_CHECK_ASSERT_SVH

// same-cycle implication
`define LCBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcbc assertion failed");

// next-cycle implication
`define LCBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcbc assertion failed");

`endif

### design/lcbc_pkg.sv
package lcbc_pkg;

   localparam int NUM_BITS   = 63;
   localparam int NUM_DIGITS = 19;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int BITCNT_W   = $clog2(NUM_BITS);
   localparam int COUNT_W    = 5;

   localparam logic [3:0] DEC_BASE  = 4'd10;
   localparam logic [3:0] DIG_FIVE  = 4'd5;
   localparam logic [3:0] DIG_FOUR  = 4'd4;
   localparam logic [3:0] DIG_THREE = 4'd3;
   localparam logic [3:0] DIG_SEVEN = 4'd7;
   localparam logic [3:0] DIG_ONE   = 4'd1;

   localparam logic [COUNT_W-1:0] LEN_CLASS1  = 5'd16;
   localparam logic [COUNT_W-1:0] LEN_CLASS2A = 5'd13;
   localparam logic [COUNT_W-1:0] LEN_CLASS2B = 5'd16;
   localparam logic [COUNT_W-1:0] LEN_CLASS3  = 5'd15;

   typedef enum logic [1:0] {
      BRAND_INVALID = 2'd0,
      BRAND_CLASS1  = 2'd1,
      BRAND_CLASS2  = 2'd2,
      BRAND_CLASS3  = 2'd3
   } brand_type;

   // doubled digit folded to its digit sum
   function automatic logic [3:0] luhn_double(input logic [3:0] d);
      logic [4:0] p;
      p = {d, 1'b0};
      if (p >= {1'b0, DEC_BASE}) begin
         luhn_double = 4'(p - 5'd9);
      end else begin
         luhn_double = p[3:0];
      end
   endfunction

   // digit sum modulo ten
   function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
      logic [4:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, DEC_BASE}) begin
         add_mod10 = 4'(s - {1'b0, DEC_BASE});
      end else begin
         add_mod10 = s[3:0];
      end
   endfunction

endpackage

### design/luhn_card_brand_check.sv
// Luhn mod-10 check with brand classification of a card number.
// Sequence: shift-add-3 binary-to-BCD conversion over all 63 input bits, then
// a scan of the decimal digits, lowest first (0..19), then a closing step.
// A new start is taken only while idle (busy low): one item in flight at a time.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
// Synchronous active-high reset returns the sequencer to idle, no result pending.
module luhn_card_brand_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [lcbc_pkg::NUM_BITS-1:0]  req_card_number,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_brand,
   output logic                           rsp_luhn_ok,
   output logic [lcbc_pkg::COUNT_W-1:0]   rsp_digit_count
);
   import lcbc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN
   } state_type;

   state_type             state_ff, state_in;
   logic [NUM_BITS-1:0]   bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in, bcd_step;
   logic [BITCNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [3:0]            total_ff, total_in;
   logic [3:0]            lead_hi_ff, lead_hi_in;
   logic [3:0]            lead_lo_ff, lead_lo_in;
   logic                  valid_ff, valid_in;
   brand_type             brand_ff, brand_in;
   logic                  ok_ff, ok_in;
   logic [3:0]            digit;
   logic [3:0]            weighted;
   logic                  pass;

   lcbc_bcd_step u_step (
      .bcd_i (bcd_ff),
      .bit_i (bin_ff[NUM_BITS-1]),
      .bcd_o (bcd_step)
   );

   assign digit    = bcd_ff[3:0];
   assign weighted = count_ff[0] ? luhn_double(digit) : digit;
   assign pass     = (total_ff == 4'd0);

   always_comb begin
      state_in   = state_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      lead_hi_in = lead_hi_ff;
      lead_lo_in = lead_lo_ff;
      valid_in   = 1'b0;
      brand_in   = brand_ff;
      ok_in      = ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in   = ST_CONV;
               bin_in     = req_card_number;
               bcd_in     = '0;
               bit_cnt_in = '0;
               count_in   = '0;
               total_in   = '0;
               lead_hi_in = '0;
               lead_lo_in = '0;
            end
         end
         ST_CONV: begin
            bcd_in = bcd_step;
            bin_in = {bin_ff[NUM_BITS-2:0], 1'b0};
            if (bit_cnt_ff == BITCNT_W'(NUM_BITS - 1)) begin
               state_in = ST_SCAN;
            end else begin
               bit_cnt_in = bit_cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (bcd_ff == '0) begin
               state_in = ST_IDLE;
               valid_in = 1'b1;
               ok_in    = pass;
               brand_in = BRAND_INVALID;
               if (pass) begin
                  priority if (lead_hi_ff == DIG_FIVE && lead_lo_ff >= DIG_ONE &&
                               lead_lo_ff <= DIG_FIVE && count_ff == LEN_CLASS1) begin
                     brand_in = BRAND_CLASS1;
                  end else if (lead_hi_ff == DIG_FOUR &&
                               (count_ff == LEN_CLASS2A || count_ff == LEN_CLASS2B)) begin
                     brand_in = BRAND_CLASS2;
                  end else if (lead_hi_ff == DIG_THREE &&
                               (lead_lo_ff == DIG_FOUR || lead_lo_ff == DIG_SEVEN) &&
                               count_ff == LEN_CLASS3) begin
                     brand_in = BRAND_CLASS3;
                  end else begin
                     brand_in = BRAND_INVALID;
                  end
               end
            end else begin
               total_in   = add_mod10(total_ff, weighted);
               bcd_in     = {4'd0, bcd_ff[BCD_W-1:4]};
               count_in   = count_ff + 1'b1;
               lead_lo_in = lead_hi_ff;
               lead_hi_in = digit;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      count_ff   <= count_in;
      total_ff   <= total_in;
      lead_hi_ff <= lead_hi_in;
      lead_lo_ff <= lead_lo_in;
      brand_ff   <= brand_in;
      ok_ff      <= ok_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_brand       = brand_ff;
   assign rsp_luhn_ok     = ok_ff;
   assign rsp_digit_count = count_ff;

`include "luhn_card_brand_check_assert.svh"

   `LCBC_ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `LCBC_ASSERT_IMPL(a_brand_needs_ok, clock, reset,
                     rsp_valid && rsp_brand != BRAND_INVALID, rsp_luhn_ok)
   `LCBC_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy && !rsp_valid)
   `LCBC_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)

endmodule

### design/lcbc_bcd_step.sv
module lcbc_bcd_step (
   input  logic [lcbc_pkg::BCD_W-1:0] bcd_i,
   input  logic                       bit_i,
   output logic [lcbc_pkg::BCD_W-1:0] bcd_o
);
   import lcbc_pkg::*;

   logic [BCD_W-1:0] adj;

   // add-3 correction on every digit, then shift in the next binary bit
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_i[4*i +: 4] >= DIG_FIVE) begin
            adj[4*i +: 4] = bcd_i[4*i +: 4] + DIG_THREE;
         end else begin
            adj[4*i +: 4] = bcd_i[4*i +: 4];
         end
      end
   end

   assign bcd_o = {adj[BCD_W-2:0], bit_i};

endmodule
